// ===== rtl/core/sfdr_pkg.sv =====
`default_nettype none
package sfdr_pkg;

	localparam int STORE_DEPTH = 32768;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int LEN_W       = ADDR_W + 1;
	localparam int LEN_MIN     = 16;

	localparam int SINE_DEPTH  = 1024;
	localparam int SINE_W      = $clog2(SINE_DEPTH);
	localparam int QUARTER     = SINE_DEPTH / 4;
	localparam int QIDX_W      = $clog2(QUARTER + 1);

	localparam int SMP_W       = 24;
	localparam int COEF_W      = 25;
	localparam int MUL_W       = 27;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int ST_W        = 42;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_W       = 32;

	localparam logic [COEF_W-1:0] Q24_ONE       = 25'd16777216;
	localparam logic [23:0]       FEEDBACK_Q24  = 24'd13421773;
	localparam logic [23:0]       ROT_Q24       = 24'd11507385;
	localparam logic [17:0]       LFO_RIGHT_Q24 = 18'd167772;
	localparam logic [31:0]       HALF_PI_Q30   = 32'd1686629713;
	localparam logic [31:0]       Q30_ONE       = 32'd1073741824;

	localparam logic [2:0] FIDX_LAST = 3'd5;
	localparam logic [1:0] ROT_LAST  = 2'd2;

	typedef logic [23:0] tap_arr_t [5];
	localparam tap_arr_t TAP_L = '{24'd0, 24'd2446118, 24'd4348654, 24'd6016175, 24'd6039798};
	localparam tap_arr_t TAP_R = '{24'd8388608, 24'd11227313, 24'd12468827, 24'd14067561,
		24'd14428406};

	typedef logic [6:0] tdiv_arr_t [5];
	localparam tdiv_arr_t TAYLOR_DIV = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELAY_LENGTH   = 2'd0,
		CFG_LOWPASS_COEFF  = 2'd1,
		CFG_HIGHPASS_COEFF = 2'd2,
		CFG_LFO_INCREMENT  = 2'd3
	} cfg_reg_t;

	typedef enum logic [5:0] {
		S_IDLE, S_AL_M, S_AR_M, S_AR_A, S_RD_R, S_RD_W,
		S_F_DIFF, S_F_LO, S_F_HI, S_F_ACC, S_WB_L, S_WB_R,
		S_LFO_PH, S_LFO_SN, S_LFO_CS, S_LFO_XR,
		S_R_MA, S_R_MB, S_R_AB, S_R_RA, S_R_RB, S_R_VB, S_R_M1, S_R_M2, S_R_W2,
		S_C_M1, S_C_P, S_C_M2, S_C_W, S_C_B, S_C_R1, S_C_R2, S_C_M3, S_C_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [SMP_W-1:0]  wdata;
	} mem_req_t;

	typedef logic [COEF_W-1:0] qtab_t [QUARTER+1];

	function automatic qtab_t build_qtab();
		qtab_t       tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int a = 0; a <= QUARTER; a++) begin
			x  = (64'(HALF_PI_Q30) * 64'(a)) / 64'(QUARTER);
			x2 = (x * x) >> 30;
			t  = 64'(Q30_ONE);
			for (int i = 0; i < 5; i++) begin
				t = 64'(Q30_ONE) - ((x2 * t) >> 30) / 64'(TAYLOR_DIV[i]);
			end
			s = (((x * t) >> 30) + 64'd32) >> 6;
			if (s > 64'(Q24_ONE)) begin
				s = 64'(Q24_ONE);
			end
			tab[a] = s[COEF_W-1:0];
		end
		return tab;
	endfunction

	localparam qtab_t QTAB = build_qtab();

	function automatic logic signed [SMP_W-1:0] sat24(logic signed [47:0] v);
		if (v > 48'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -48'sd8388608) begin
			return 24'sh800000;
		end
		return v[SMP_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] tap_addr(logic [LEN_W-1:0] off,
		logic [ADDR_W-1:0] wp, logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] o;
		logic [LEN_W:0]   p;
		o = (off > len) ? len : off;
		p = {2'b00, wp} + {1'b0, len} - {1'b0, o};
		if (p >= {1'b0, len}) begin
			p = p - {1'b0, len};
		end
		return p[ADDR_W-1:0];
	endfunction

	function automatic logic [23:0] tap_c(logic side, logic [2:0] idx);
		return side ? TAP_R[idx] : TAP_L[idx];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sfdr_mem.sv =====
`default_nettype none
module sfdr_mem (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sfdr_pkg::mem_req_t                 req,
	output logic [sfdr_pkg::SMP_W-1:0]         rdata,
	output logic                               busy
);
	import sfdr_pkg::*;

	logic [SMP_W-1:0]  mem [STORE_DEPTH];
	logic [ADDR_W:0]   clr_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [SMP_W-1:0]  wr_data;

	assign busy    = ~clr_q[ADDR_W];
	assign wr_en   = busy | req.we;
	assign wr_addr = busy ? clr_q[ADDR_W-1:0] : req.addr;
	assign wr_data = busy ? '0 : req.wdata;

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata <= mem[req.addr];
	end

endmodule
`default_nettype wire

// ===== rtl/core/sfdr_mul.sv =====
`default_nettype none
module sfdr_mul (
	input  logic                                 clk,
	input  logic signed [sfdr_pkg::MUL_W-1:0]    a,
	input  logic signed [sfdr_pkg::MUL_W-1:0]    b,
	output logic signed [sfdr_pkg::PROD_W-1:0]   p
);
	import sfdr_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule
`default_nettype wire

// ===== rtl/core/stereo_feedback_delay_reverb_unit.sv =====
`default_nettype none
// frames are processed one at a time: a new input transfer is taken only after the
// previous result has been loaded for output, which waits while the output is held;
// those of the six rotations whose two taps fall on the same address are skipped. The
// pace is set by the single delay store port and the one shared 27x27 multiplier
// stepped by the sequencer
// reset: control and filter state clear at once, config registers load their defaults;
// the delay store is then zeroed, during which no input transfer is taken
module stereo_feedback_delay_reverb_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [47:0]                       s_axis_tdata,  // left_in, right_in
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [47:0]                       m_axis_tdata,  // left_out, right_out
	input  logic                              cfg_we,
	input  logic [sfdr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfdr_pkg::CFG_W-1:0]        cfg_data
);
	import sfdr_pkg::*;

	state_t state_q, state_d;

	logic [15:0]       delay_length_q;
	logic [COEF_W-1:0] lowpass_coeff_q, highpass_coeff_q;
	logic [31:0]       lfo_increment_q;

	logic [LEN_W-1:0]  len_q, len_n;
	logic [ADDR_W-1:0] wp_q;
	logic [31:0]       phase_q;
	logic signed [ST_W-1:0] lpl_q, hpl_q, lpr_q, hpr_q, fbl_q, fbr_q;
	logic [2:0]        fidx_q;
	logic [1:0]        ridx_q;
	logic              side_q;
	logic              out_valid_q;
	logic signed [SMP_W-1:0] out_l_q, out_r_q;

	logic signed [SMP_W-1:0] in_l_q, in_r_q, va_q;
	logic signed [ST_W-1:0]  d_q;
	logic [24:0]             lo_q;
	logic [ADDR_W-1:0]       al_q, ar_q, a_q, b_q, w0_q, w1_q;
	logic signed [24:0]      sum_q, dif_q;
	logic [25:0]             sn_q;
	logic [24:0]             xl_q, xr_q;
	logic [23:0]             p_q, frac_q;

	mem_req_t                 mem_req;
	logic [SMP_W-1:0]         mem_rdata;
	logic signed [SMP_W-1:0]  rd_s;
	logic                     mem_busy;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] mul_p;

	logic [31:0]             dl32;
	logic [COEF_W-1:0]       lc, hc, f_c;
	logic signed [ST_W-1:0]  tl, tr, f_s, f_t, f_res;
	logic [LEN_W-1:0]        off_w, whole_w;
	logic [SINE_W-1:0]       k, k_sel;
	logic [QIDX_W-1:0]       qa;
	logic signed [25:0]      sine_v;
	logic [25:0]             sine_off;
	logic [24:0]             x_sel;
	logic [2:0]              ri0, ri1;
	logic [ADDR_W:0]         wp_inc;
	logic                    in_xfer, out_load;
	state_t                  rot_next;

	sfdr_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rdata  (mem_rdata),
		.busy   (mem_busy)
	);

	sfdr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign rd_s     = $signed(mem_rdata);
	assign in_xfer  = s_axis_tvalid & s_axis_tready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_r_q, out_l_q};

	always_comb begin
		dl32 = 32'(delay_length_q);
		if (dl32 < 32'(LEN_MIN)) begin
			len_n = LEN_W'(LEN_MIN);
		end else if (dl32 > 32'(STORE_DEPTH)) begin
			len_n = LEN_W'(STORE_DEPTH);
		end else begin
			len_n = LEN_W'(dl32);
		end
	end

	assign lc = (lowpass_coeff_q > Q24_ONE) ? Q24_ONE : lowpass_coeff_q;
	assign hc = (highpass_coeff_q > Q24_ONE) ? Q24_ONE : highpass_coeff_q;
	assign tl = lpl_q - hpl_q;
	assign tr = lpr_q - hpr_q;

	assign off_w   = mul_p[LEN_W+23:24];
	assign whole_w = mul_p[LEN_W+23:24];
	assign x_sel   = side_q ? xr_q : xl_q;
	assign ri0     = {1'b0, ridx_q};
	assign ri1     = {1'b0, ridx_q} + 3'd1;
	assign wp_inc  = {1'b0, wp_q} + 1'b1;
	assign rot_next = (ridx_q == ROT_LAST) ? S_C_M1 : S_R_MA;

	// lfo quarter-wave lookup
	assign k     = phase_q[31 -: SINE_W];
	assign k_sel = (state_q == S_LFO_CS) ? k + SINE_W'(QUARTER) : k;
	always_comb begin
		if (k_sel[SINE_W-2]) begin
			qa = QIDX_W'(QUARTER) - QIDX_W'(k_sel[SINE_W-3:0]);
		end else begin
			qa = QIDX_W'(k_sel[SINE_W-3:0]);
		end
		sine_v   = k_sel[SINE_W-1] ? -$signed({1'b0, QTAB[qa]}) : $signed({1'b0, QTAB[qa]});
		sine_off = unsigned'(sine_v) + 26'd16777216;
	end

	// filter operand selection
	always_comb begin
		case (fidx_q)
			3'd0: begin
				f_s = lpl_q;
				f_t = ST_W'(va_q) <<< 16;
				f_c = lc;
			end
			3'd1: begin
				f_s = hpl_q;
				f_t = lpl_q;
				f_c = hc;
			end
			3'd2: begin
				f_s = lpr_q;
				f_t = fbr_q <<< 16;
				f_c = lc;
			end
			3'd3: begin
				f_s = hpr_q;
				f_t = lpr_q;
				f_c = hc;
			end
			3'd4: begin
				f_s = '0;
				f_t = tl;
				f_c = COEF_W'(FEEDBACK_Q24);
			end
			default: begin
				f_s = '0;
				f_t = tr;
				f_c = COEF_W'(FEEDBACK_Q24);
			end
		endcase
		f_res = f_s + ST_W'(mul_p) + ST_W'({1'b0, lo_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q   <= 16'd24000;
			lowpass_coeff_q  <= 25'd12800000;
			highpass_coeff_q <= 25'd65800;
			lfo_increment_q  <= 32'd89478;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_DELAY_LENGTH:   delay_length_q   <= cfg_data[15:0];
				CFG_LOWPASS_COEFF:  lowpass_coeff_q  <= cfg_data[COEF_W-1:0];
				CFG_HIGHPASS_COEFF: highpass_coeff_q <= cfg_data[COEF_W-1:0];
				CFG_LFO_INCREMENT:  lfo_increment_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_xfer) state_d = S_AL_M;
			S_AL_M:    state_d = S_AR_M;
			S_AR_M:    state_d = S_AR_A;
			S_AR_A:    state_d = S_RD_R;
			S_RD_R:    state_d = S_RD_W;
			S_RD_W:    state_d = S_F_DIFF;
			S_F_DIFF:  state_d = S_F_LO;
			S_F_LO:    state_d = S_F_HI;
			S_F_HI:    state_d = S_F_ACC;
			S_F_ACC:   state_d = (fidx_q == FIDX_LAST) ? S_WB_L : S_F_DIFF;
			S_WB_L:    state_d = S_WB_R;
			S_WB_R:    state_d = S_LFO_PH;
			S_LFO_PH:  state_d = S_LFO_SN;
			S_LFO_SN:  state_d = S_LFO_CS;
			S_LFO_CS:  state_d = S_LFO_XR;
			S_LFO_XR:  state_d = S_R_MA;
			S_R_MA:    state_d = S_R_MB;
			S_R_MB:    state_d = S_R_AB;
			S_R_AB:    state_d = S_R_RA;
			S_R_RA:    state_d = (a_q == b_q) ? rot_next : S_R_RB;
			S_R_RB:    state_d = S_R_VB;
			S_R_VB:    state_d = S_R_M1;
			S_R_M1:    state_d = S_R_M2;
			S_R_M2:    state_d = S_R_W2;
			S_R_W2:    state_d = rot_next;
			S_C_M1:    state_d = S_C_P;
			S_C_P:     state_d = S_C_M2;
			S_C_M2:    state_d = S_C_W;
			S_C_W:     state_d = S_C_B;
			S_C_B:     state_d = S_C_R1;
			S_C_R1:    state_d = S_C_R2;
			S_C_R2:    state_d = S_C_M3;
			S_C_M3:    state_d = S_C_WR;
			S_C_WR:    state_d = side_q ? S_DONE : S_R_MA;
			S_DONE:    if (out_load) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		mem_req       = '0;
		mul_a         = '0;
		mul_b         = '0;
		case (state_q)
			S_IDLE: s_axis_tready = ~mem_busy;
			S_AL_M: begin
				mul_a = MUL_W'(TAP_L[0]);
				mul_b = MUL_W'(len_q);
			end
			S_AR_M: begin
				mul_a = MUL_W'(TAP_R[0]);
				mul_b = MUL_W'(len_q);
			end
			S_AR_A: mem_req.addr = al_q;
			S_RD_R: mem_req.addr = ar_q;
			S_F_LO: begin
				mul_a = MUL_W'({1'b0, d_q[23:0]});
				mul_b = MUL_W'(f_c);
			end
			S_F_HI: begin
				mul_a = MUL_W'($signed(d_q[ST_W-1:24]));
				mul_b = MUL_W'(f_c);
			end
			S_WB_L: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = al_q;
				mem_req.wdata = sat24(48'(fbl_q >>> 16) + 48'(in_r_q));
			end
			S_WB_R: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = ar_q;
				mem_req.wdata = sat24(48'(fbr_q >>> 16) + 48'(in_l_q));
			end
			S_LFO_CS: begin
				mul_a = MUL_W'(sn_q);
				mul_b = MUL_W'(LFO_RIGHT_Q24);
			end
			S_R_MA: begin
				mul_a = MUL_W'(tap_c(side_q, ri0));
				mul_b = MUL_W'(len_q);
			end
			S_R_MB: begin
				mul_a = MUL_W'(tap_c(side_q, ri1));
				mul_b = MUL_W'(len_q);
			end
			S_R_RA: mem_req.addr = a_q;
			S_R_RB: mem_req.addr = b_q;
			S_R_M1: begin
				mul_a = MUL_W'(sum_q);
				mul_b = MUL_W'(ROT_Q24);
			end
			S_R_M2: begin
				mul_a         = MUL_W'(dif_q);
				mul_b         = MUL_W'(ROT_Q24);
				mem_req.we    = 1'b1;
				mem_req.addr  = a_q;
				mem_req.wdata = sat24(48'(mul_p >>> 24));
			end
			S_R_W2: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = b_q;
				mem_req.wdata = sat24(48'(mul_p >>> 24));
			end
			S_C_M1: begin
				mul_a = MUL_W'(tap_c(side_q, 3'd4) - tap_c(side_q, 3'd3));
				mul_b = MUL_W'(x_sel);
			end
			S_C_M2: begin
				mul_a = MUL_W'(p_q);
				mul_b = MUL_W'(len_q);
			end
			S_C_W: begin
				mul_a = MUL_W'(tap_c(side_q, 3'd4));
				mul_b = MUL_W'(len_q);
			end
			S_C_B:  mem_req.addr = w0_q;
			S_C_R1: mem_req.addr = w1_q;
			S_C_M3: begin
				mul_a = MUL_W'(dif_q);
				mul_b = MUL_W'(frac_q);
			end
			S_C_WR: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = b_q;
				mem_req.wdata = sat24(48'(va_q) + 48'(mul_p >>> 24));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= LEN_W'(LEN_MIN);
			wp_q        <= '0;
			phase_q     <= '0;
			lpl_q       <= '0;
			hpl_q       <= '0;
			lpr_q       <= '0;
			hpr_q       <= '0;
			fidx_q      <= '0;
			ridx_q      <= '0;
			side_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						len_q <= len_n;
						if ({1'b0, wp_q} >= len_n) begin
							wp_q <= '0;
						end
					end
				end
				S_RD_W: fidx_q <= '0;
				S_F_ACC: begin
					case (fidx_q)
						3'd0: lpl_q <= f_res;
						3'd1: hpl_q <= f_res;
						3'd2: lpr_q <= f_res;
						3'd3: hpr_q <= f_res;
						default: ;
					endcase
					fidx_q <= fidx_q + 3'd1;
				end
				S_LFO_PH: phase_q <= phase_q + lfo_increment_q;
				S_LFO_XR: begin
					side_q <= 1'b0;
					ridx_q <= '0;
				end
				S_R_RA: begin
					if (a_q == b_q) begin
						ridx_q <= (ridx_q == ROT_LAST) ? 2'd0 : ridx_q + 2'd1;
					end
				end
				S_R_W2: ridx_q <= (ridx_q == ROT_LAST) ? 2'd0 : ridx_q + 2'd1;
				S_C_WR: side_q <= 1'b1;
				S_DONE: begin
					if (out_load) begin
						wp_q <= (wp_inc >= {1'b0, len_q}) ? '0 : wp_inc[ADDR_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				in_l_q <= $signed(s_axis_tdata[23:0]);
				in_r_q <= $signed(s_axis_tdata[47:24]);
			end
			S_AR_M:   al_q <= tap_addr(off_w, wp_q, len_q);
			S_AR_A:   ar_q <= tap_addr(off_w, wp_q, len_q);
			S_RD_R:   va_q <= rd_s;
			S_RD_W:   begin
				// right tap sample
				fbr_q <= ST_W'(rd_s);
			end
			S_F_DIFF: d_q <= f_t - f_s;
			S_F_HI:   lo_q <= mul_p[48:24];
			S_F_ACC: begin
				if (fidx_q == 3'd4) begin
					fbl_q <= f_res;
				end else if (fidx_q == FIDX_LAST) begin
					fbr_q <= f_res;
				end
			end
			S_LFO_SN: sn_q <= sine_off;
			S_LFO_CS: xl_q <= sine_off[25:1];
			S_LFO_XR: xr_q <= 25'd8388608 + 25'(mul_p[42:24]) - 25'(LFO_RIGHT_Q24);
			S_R_MB:   a_q <= tap_addr(off_w, wp_q, len_q);
			S_R_AB:   b_q <= tap_addr(off_w, wp_q, len_q);
			S_R_RB:   va_q <= rd_s;
			S_R_VB: begin
				sum_q <= 25'(va_q) + 25'(rd_s);
				dif_q <= 25'(va_q) - 25'(rd_s);
			end
			S_C_P:    p_q <= tap_c(side_q, 3'd3) + mul_p[47:24];
			S_C_W: begin
				w0_q   <= tap_addr(whole_w, wp_q, len_q);
				w1_q   <= tap_addr(whole_w + 1'b1, wp_q, len_q);
				frac_q <= mul_p[23:0];
			end
			S_C_B:    b_q <= tap_addr(off_w, wp_q, len_q);
			S_C_R1:   va_q <= rd_s;
			S_C_R2:   dif_q <= 25'(rd_s) - 25'(va_q);
			S_DONE: begin
				if (out_load) begin
					out_l_q <= sat24(48'(in_l_q) + 48'(tl >>> 18));
					out_r_q <= sat24(48'(in_r_q) + 48'(tr >>> 18));
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire
